### rtl/dcm_pkg.sv
`timescale 1ns / 1ps
package dcm_pkg;
    localparam int BUF_BYTES = 256;
    localparam int BUF_AW = 8;
    localparam int WORD_BYTES = 8;

    localparam logic [3:0] PH_FIRST     = 4'd0;
    localparam logic [3:0] PH_BLOCK     = 4'd1;
    localparam logic [3:0] PH_DENS      = 4'd2;
    localparam logic [3:0] PH_NUM_LO    = 4'd3;
    localparam logic [3:0] PH_NUM_HI    = 4'd4;
    localparam logic [3:0] PH_TAIL_LEN  = 4'd5;
    localparam logic [3:0] PH_TAIL_DATA = 4'd6;
    localparam logic [3:0] PH_SPAN_OFF  = 4'd7;
    localparam logic [3:0] PH_SPAN_RAW  = 4'd8;
    localparam logic [3:0] PH_FILL_OFF  = 4'd9;
    localparam logic [3:0] PH_FILL_BYTE = 4'd10;
    localparam logic [3:0] PH_REPL_OFF  = 4'd11;
    localparam logic [3:0] PH_REPL_DATA = 4'd12;
    localparam logic [3:0] PH_RAW_DATA  = 4'd13;

    localparam logic [2:0] ST_WORD    = 3'd0;
    localparam logic [2:0] ST_OPENED  = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_BAD_HDR = 3'd3;
    localparam logic [2:0] ST_BAD_BLK = 3'd4;
    localparam logic [2:0] ST_BAD_DEN = 3'd5;
    localparam logic [2:0] ST_NOT_CLS = 3'd6;
    localparam logic [2:0] ST_TRUNC   = 3'd7;

    localparam logic [7:0] BT_F9 = 8'hF9;
    localparam logic [7:0] BT_FA = 8'hFA;
    localparam logic [7:0] BT_END = 8'h45;
    localparam logic [7:0] BT_TAIL   = 8'h41;
    localparam logic [7:0] BT_SPAN   = 8'h43;
    localparam logic [7:0] BT_REPL   = 8'h44;
    localparam logic [7:0] BT_REPEAT = 8'h46;
    localparam logic [7:0] BT_RAW    = 8'h47;
    localparam logic [7:0] BT_INCR   = 8'h80;

    localparam logic [2:0] DEN_SD = 3'd0;
    localparam logic [2:0] DEN_DD = 3'd2;
    localparam logic [2:0] DEN_ED = 3'd4;

    localparam logic [10:0] SECT_SD = 11'd720;
    localparam logic [10:0] SECT_ED = 11'd1040;
endpackage

### rtl/dcm_sector_ram.sv
`timescale 1ns / 1ps
module dcm_sector_ram
    import dcm_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [BUF_AW-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [BUF_AW-1:0] raddr,
    output logic [7:0]        rdata
);
    logic [7:0] mem [BUF_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/dcm_disk_image_decoder_top.sv
`timescale 1ns / 1ps
// a header or data byte is taken in S_IDLE; some bytes also raise a status beat
// a byte that ends a sector starts the read-out of 16 or 32 words (per word eight
// single-byte ram reads, then the word beat is loaded once the result register is free)
// a fill byte starts a run of buffer writes (one buffer write per cycle)
// reset and new_file run a clearing pass over all 256 sector buffer bytes, input held off
// the result register holds one beat; a new byte is taken only once it is empty
module dcm_disk_image_decoder_top
    import dcm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              data_byte,
    input  logic                    end_of_input,
    input  logic                    new_file,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              status,
    output logic [15:0]             sector_number,
    output logic [8:0]              sector_bytes,
    output logic [10:0]             disk_sectors,
    output logic [4:0]              word_index,
    output logic [8*WORD_BYTES-1:0] data_word,
    output logic                    last_word
);
    localparam int WBW = $clog2(WORD_BYTES) + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_FILL  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [15:0] cur_reg, cur_next;
    logic        large_reg, large_next;
    logic [10:0] total_reg, total_next;
    logic        open_reg, open_next;
    logic        final_reg, final_next;
    logic [3:0]  ph_reg, ph_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  rend_reg, rend_next;
    logic [7:0]  lo_reg, lo_next;
    logic [7:0]  bt_reg, bt_next;
    logic        f9_reg, f9_next;
    logic        stop_reg, stop_next;
    logic [7:0]  fill_reg, fill_next;
    logic [8:0]  cnt_reg, cnt_next;   // clear / read byte counter
    logic [8:0]  nbytes_reg, nbytes_next;
    logic [WBW-1:0] bi_reg, bi_next;
    logic [8*WORD_BYTES-1:0] acc_reg, acc_next;
    logic        rdv_reg;
    logic        ov_reg, ov_next;
    logic [2:0]  ost_reg, ost_next;
    logic [8:0]  obytes_reg, obytes_next;
    logic [4:0]  oidx_reg, oidx_next;
    logic [8*WORD_BYTES-1:0] ow_reg, ow_next;
    logic        olast_reg, olast_next;
    logic [15:0] onum_reg, onum_next;
    logic [10:0] otot_reg, otot_next;

    logic        we;
    logic [7:0]  waddr, wdata, raddr, rdata;

    dcm_sector_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    logic [8:0] dsize, ssize, off;
    assign dsize = large_reg ? 9'd256 : 9'd128;
    assign ssize = (cur_reg < 16'd4) ? 9'd128 : dsize;
    assign off = (data_byte == 8'd0) ? 9'd256 : {1'b0, data_byte};
    assign in_ready = (st_reg == S_IDLE) && !ov_reg;

    logic acc_in;
    assign acc_in = in_valid && in_ready;

    always_comb
    begin
        logic emit, rep;
        logic [2:0] rst_code;
        st_next = st_reg; cur_next = cur_reg; large_next = large_reg;
        total_next = total_reg; open_next = open_reg; final_next = final_reg;
        ph_next = ph_reg; pos_next = pos_reg; rend_next = rend_reg; lo_next = lo_reg;
        bt_next = bt_reg; f9_next = f9_reg; stop_next = stop_reg; fill_next = fill_reg;
        cnt_next = cnt_reg; nbytes_next = nbytes_reg; bi_next = bi_reg; acc_next = acc_reg;
        ov_next = ov_reg; ost_next = ost_reg; obytes_next = obytes_reg; oidx_next = oidx_reg;
        ow_next = ow_reg; olast_next = olast_reg; onum_next = onum_reg; otot_next = otot_reg;
        we = 1'b0; waddr = pos_reg[7:0]; wdata = data_byte; raddr = cnt_reg[7:0];
        emit = 1'b0; rep = 1'b0; rst_code = ST_WORD;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (st_reg)
            S_CLEAR:
            begin
                we = 1'b1; waddr = cnt_reg[7:0]; wdata = 8'd0;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd255)
                begin
                    st_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc_in && new_file)
                begin
                    // restart: clear state and check this beat's byte as the header byte, then sweep the buffer
                    cur_next = '0; large_next = 1'b0; total_next = '0; open_next = 1'b0;
                    final_next = 1'b0; pos_next = '0; rend_next = '0; lo_next = '0;
                    bt_next = '0; f9_next = 1'b0; stop_next = 1'b0;
                    if (end_of_input)
                    begin
                        // report immediately on cleared state, buffer still swept
                        stop_next = 1'b1;
                        ost_next = ST_TRUNC; obytes_next = 9'd128; onum_next = '0;
                        otot_next = '0; oidx_next = '0; ow_next = '0; olast_next = 1'b1;
                        ov_next = 1'b1;
                        ph_next = PH_FIRST;
                    end
                    else if (data_byte != BT_F9 && data_byte != BT_FA)
                    begin
                        stop_next = 1'b1;
                        ost_next = ST_BAD_HDR; obytes_next = 9'd128; onum_next = '0;
                        otot_next = '0; oidx_next = '0; ow_next = '0; olast_next = 1'b1;
                        ov_next = 1'b1;
                        ph_next = PH_FIRST;
                    end
                    else
                    begin
                        f9_next = (data_byte == BT_F9);
                        bt_next = data_byte;
                        ph_next = PH_DENS;
                    end
                    cnt_next = '0;
                    st_next = S_CLEAR;
                end
                else if (acc_in && !stop_reg)
                begin
                    if (end_of_input)
                    begin
                        rep = 1'b1; rst_code = ST_TRUNC; stop_next = 1'b1;
                    end
                    else
                    begin
                        unique case (ph_reg)
                            PH_FIRST:
                            begin
                                if (data_byte != BT_F9 && data_byte != BT_FA)
                                begin
                                    rep = 1'b1; rst_code = ST_BAD_HDR; stop_next = 1'b1;
                                end
                                else
                                begin
                                    f9_next = (data_byte == BT_F9);
                                    bt_next = data_byte;
                                    ph_next = PH_DENS;
                                end
                            end
                            PH_BLOCK:
                            begin
                                bt_next = data_byte;
                                unique case (data_byte)
                                    BT_F9, BT_FA:
                                    begin
                                        if (open_reg)
                                        begin
                                            rep = 1'b1; rst_code = ST_NOT_CLS;
                                            stop_next = 1'b1;
                                        end
                                        else
                                        begin
                                            ph_next = PH_DENS;
                                        end
                                    end
                                    BT_END:
                                    begin
                                        open_next = 1'b0;
                                        if (final_reg)
                                        begin
                                            rep = 1'b1; rst_code = ST_DONE; stop_next = 1'b1;
                                        end
                                    end
                                    BT_TAIL, BT_TAIL | BT_INCR: ph_next = PH_TAIL_LEN;
                                    BT_SPAN, BT_SPAN | BT_INCR:
                                    begin
                                        pos_next = '0; ph_next = PH_SPAN_OFF;
                                    end
                                    BT_REPL, BT_REPL | BT_INCR: ph_next = PH_REPL_OFF;
                                    BT_REPEAT, BT_REPEAT | BT_INCR: emit = 1'b1;
                                    BT_RAW, BT_RAW | BT_INCR:
                                    begin
                                        pos_next = '0; ph_next = PH_RAW_DATA;
                                    end
                                    default:
                                    begin
                                        rep = 1'b1; rst_code = ST_BAD_BLK; stop_next = 1'b1;
                                    end
                                endcase
                            end
                            PH_DENS:
                            begin
                                final_next = data_byte[7];
                                unique case (data_byte[6:4])
                                    DEN_SD:
                                    begin
                                        total_next = SECT_SD; large_next = 1'b0;
                                        ph_next = PH_NUM_LO;
                                    end
                                    DEN_DD:
                                    begin
                                        total_next = SECT_SD; large_next = 1'b1;
                                        ph_next = PH_NUM_LO;
                                    end
                                    DEN_ED:
                                    begin
                                        total_next = SECT_ED; large_next = 1'b0;
                                        ph_next = PH_NUM_LO;
                                    end
                                    default:
                                    begin
                                        rep = 1'b1; rst_code = ST_BAD_DEN; stop_next = 1'b1;
                                    end
                                endcase
                            end
                            PH_NUM_LO:
                            begin
                                lo_next = data_byte; ph_next = PH_NUM_HI;
                            end
                            PH_NUM_HI:
                            begin
                                cur_next = {data_byte, lo_reg};
                                ph_next = PH_BLOCK;
                                if (bt_reg == BT_F9 || bt_reg == BT_FA)
                                begin
                                    open_next = 1'b1;
                                    ost_next = ST_OPENED; obytes_next = dsize;
                                    onum_next = {data_byte, lo_reg}; otot_next = total_reg;
                                    oidx_next = '0; ow_next = '0; olast_next = 1'b1;
                                    ov_next = 1'b1;
                                end
                            end
                            PH_TAIL_LEN:
                            begin
                                pos_next = {1'b0, data_byte}; ph_next = PH_TAIL_DATA;
                            end
                            PH_TAIL_DATA:
                            begin
                                we = 1'b1;
                                if (pos_reg == 9'd0)
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    pos_next = pos_reg - 9'd1;
                                end
                            end
                            PH_SPAN_OFF:
                            begin
                                logic [8:0] re;
                                re = (pos_reg != 9'd0) ? off : {1'b0, data_byte};
                                rend_next = re;
                                if (pos_reg < re)
                                begin
                                    ph_next = PH_SPAN_RAW;
                                end
                                else if (pos_reg == dsize)
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    ph_next = PH_FILL_OFF;
                                end
                            end
                            PH_SPAN_RAW:
                            begin
                                we = 1'b1;
                                pos_next = pos_reg + 9'd1;
                                if (pos_reg + 9'd1 >= rend_reg)
                                begin
                                    if (pos_reg + 9'd1 == dsize)
                                    begin
                                        emit = 1'b1;
                                    end
                                    else
                                    begin
                                        ph_next = PH_FILL_OFF;
                                    end
                                end
                            end
                            PH_FILL_OFF:
                            begin
                                rend_next = off; ph_next = PH_FILL_BYTE;
                            end
                            PH_FILL_BYTE:
                            begin
                                fill_next = data_byte;
                                st_next = S_FILL;
                            end
                            PH_REPL_OFF:
                            begin
                                pos_next = off;
                                if (off >= dsize)
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    ph_next = PH_REPL_DATA;
                                end
                            end
                            PH_REPL_DATA:
                            begin
                                we = 1'b1;
                                pos_next = pos_reg + 9'd1;
                                if (pos_reg + 9'd1 >= dsize)
                                begin
                                    emit = 1'b1;
                                end
                            end
                            PH_RAW_DATA:
                            begin
                                we = 1'b1;
                                pos_next = pos_reg + 9'd1;
                                if (pos_reg + 9'd1 >= ssize)
                                begin
                                    emit = 1'b1;
                                end
                            end
                            default:
                            begin
                                ph_next = PH_BLOCK;
                            end
                        endcase
                    end
                end
            end
            S_FILL:
            begin
                // one buffer byte per cycle until the run end
                if (pos_reg < rend_reg)
                begin
                    we = 1'b1; wdata = fill_reg;
                    pos_next = pos_reg + 9'd1;
                end
                else if (pos_reg < dsize)
                begin
                    ph_next = PH_SPAN_OFF; st_next = S_IDLE;
                end
                else
                begin
                    emit = 1'b1;
                end
            end
            S_RD:
            begin
                // byte in flight from the previous cycle lands here
                if (rdv_reg)
                begin
                    acc_next = {rdata, acc_reg[8*WORD_BYTES-1:8]};
                end
                if (bi_reg == WBW'(WORD_BYTES))
                begin
                    if (!ov_reg || out_ready)
                    begin
                        ost_next = ST_WORD; obytes_next = nbytes_reg; onum_next = cur_reg;
                        otot_next = total_reg; oidx_next = 5'(cnt_reg[8:$clog2(WORD_BYTES)] - 1'b1);
                        ow_next = acc_next; olast_next = (cnt_reg == nbytes_reg);
                        ov_next = 1'b1; bi_next = '0;
                        if (cnt_reg == nbytes_reg)
                        begin
                            st_next = S_IDLE;
                            if (bt_reg[7])
                            begin
                                cur_next = cur_reg + 16'd1; ph_next = PH_BLOCK;
                            end
                            else
                            begin
                                ph_next = PH_NUM_LO;
                            end
                        end
                    end
                end
                else
                begin
                    raddr = cnt_reg[7:0];
                    cnt_next = cnt_reg + 9'd1;
                    bi_next = bi_reg + 1'b1;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            nbytes_next = ssize; cnt_next = '0; bi_next = '0; st_next = S_RD;
        end
        if (rep)
        begin
            ost_next = rst_code; obytes_next = dsize; onum_next = cur_reg;
            otot_next = total_reg; oidx_next = '0; ow_next = '0; olast_next = 1'b1;
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLEAR; cur_reg <= '0; large_reg <= 1'b0; total_reg <= '0;
            open_reg <= 1'b0; final_reg <= 1'b0; ph_reg <= PH_FIRST; pos_reg <= '0;
            rend_reg <= '0; lo_reg <= '0; bt_reg <= '0; f9_reg <= 1'b0; stop_reg <= 1'b0;
            cnt_reg <= '0; bi_reg <= '0; rdv_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; cur_reg <= cur_next; large_reg <= large_next;
            total_reg <= total_next; open_reg <= open_next; final_reg <= final_next;
            ph_reg <= ph_next; pos_reg <= pos_next; rend_reg <= rend_next; lo_reg <= lo_next;
            bt_reg <= bt_next; f9_reg <= f9_next; stop_reg <= stop_next;
            cnt_reg <= cnt_next; bi_reg <= bi_next; ov_reg <= ov_next;
            rdv_reg <= (st_reg == S_RD) && (bi_reg != WBW'(WORD_BYTES));
        end
    end

    always_ff @(posedge clk)
    begin
        fill_reg <= fill_next; nbytes_reg <= nbytes_next; acc_reg <= acc_next;
        ost_reg <= ost_next; obytes_reg <= obytes_next; oidx_reg <= oidx_next;
        ow_reg <= ow_next; olast_reg <= olast_next; onum_reg <= onum_next;
        otot_reg <= otot_next;
    end

    assign out_valid = ov_reg;
    assign status = ost_reg;
    assign sector_number = onum_reg;
    assign sector_bytes = obytes_reg;
    assign disk_sectors = otot_reg;
    assign word_index = oidx_reg;
    assign data_word = ow_reg;
    assign last_word = olast_reg;

    a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (stop_reg && st_reg == S_IDLE && !new_file && in_valid && in_ready) |=>
        (!ov_reg || $stable(ost_reg)))
        else $error("result after stop");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg)
        else $error("result dropped");
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> !in_ready)
        else $error("ready while busy");
endmodule
